FILE: hdl/oas_pkg.sv
package oas_pkg;

	// default store size
	localparam int SECTORS_DEF = 90;

	// field widths
	localparam int SECTOR_W = 7;
	localparam int RANGE_W  = 16;
	localparam int DEG_W    = 9;
	localparam int DEAD_W   = 8;
	localparam int LIN_W    = 5;
	localparam int ANG_W    = 7;
	localparam int SIDE_W   = 2;
	localparam int FLIP_W   = 2;

	// stream packing
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// opcodes carried on s_tuser
	localparam logic OP_SCAN   = 1'b0;
	localparam logic OP_DECIDE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD      = 2'd3;

	// register reset values
	localparam logic [RANGE_W-1:0] THRESHOLD_RST = 16'd400;
	localparam logic [DEG_W-1:0]   OFFSET_RST    = 9'd25;
	localparam logic [DEG_W-1:0]   BAND_RST      = 9'd150;
	localparam logic [DEAD_W-1:0]  DEAD_RST      = 8'd1;

	localparam logic [RANGE_W-1:0] PRESET_RANGE = 16'd800;
	localparam logic [DEG_W-1:0]   FULL_TURN    = 9'd360;

	// obstacle side codes
	localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_LOW  = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_HIGH = 2'd2;

	localparam logic [FLIP_W-1:0] FLIP_LIMIT = 2'd2;

	// speeds in hundredths
	localparam logic [LIN_W-1:0] LIN_STOP   = 5'd0;
	localparam logic [LIN_W-1:0] LIN_STEER  = 5'd20;
	localparam logic [LIN_W-1:0] LIN_CRUISE = 5'd30;

	localparam logic signed [ANG_W-1:0] ANG_SPIN_L  = 7'sd40;
	localparam logic signed [ANG_W-1:0] ANG_SPIN_R  = -7'sd40;
	localparam logic signed [ANG_W-1:0] ANG_STEER_L = 7'sd20;
	localparam logic signed [ANG_W-1:0] ANG_STEER_R = -7'sd20;
	localparam logic signed [ANG_W-1:0] ANG_ZERO    = 7'sd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_RESULT
	} state_t;

endpackage

FILE: hdl/oas_cell.sv
module oas_cell #(
	parameter int SECTORS = oas_pkg::SECTORS_DEF,
	parameter int IDXW    = 7,
	parameter int K       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [oas_pkg::SECTOR_W-1:0]  wr_sector,
	input  logic [oas_pkg::RANGE_W-1:0]   wr_range,
	input  logic                          in_vld,
	input  logic [oas_pkg::RANGE_W-1:0]   in_val,
	input  logic [IDXW-1:0]               in_idx,
	output logic                          out_vld,
	output logic [oas_pkg::RANGE_W-1:0]   out_val,
	output logic [IDXW-1:0]               out_idx
);

	localparam logic [IDXW-1:0] MY_IDX = IDXW'(K);

	logic [oas_pkg::RANGE_W-1:0] range_q;
	logic                        vld_q;
	logic [oas_pkg::RANGE_W-1:0] val_q;
	logic [IDXW-1:0]             idx_q;
	logic                        take;

	// strict compare keeps the lowest index among equal minima
	assign take = (range_q < in_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= oas_pkg::PRESET_RANGE;
		end else if (wr_en && (32'(wr_sector) == K) && (K < SECTORS)) begin
			range_q <= wr_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			val_q <= take ? range_q : in_val;
			idx_q <= take ? MY_IDX : in_idx;
		end
	end

	assign out_vld = vld_q;
	assign out_val = val_q;
	assign out_idx = idx_q;

endmodule

FILE: hdl/obstacle_avoid_steering_top.sv
// scan transaction: accepted while idle and written into its sector's cell, scans may follow back to back
// decide transaction: the result is captured from the end of the chain and then loaded into the
//   output register; the running minimum walks the chain of range cells, one cell per cycle
// after a decide the next input is taken once its result is loaded, later while the last result stalls
// reset (arst_n low, asynchronous): every sector range presets to 800 mm,
//   registers take their defaults, obstacle side and flip count clear
module obstacle_avoid_steering_top #(
	parameter int SECTORS = oas_pkg::SECTORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sector_index[6:0], range_mm[22:7], heading_raw[31:23], heading_target[40:32]
	input  logic [oas_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// linear_speed[4:0], angular_speed[11:5]
	output logic [oas_pkg::M_TDATA_W-1:0]     m_tdata,
	// obstacle_mode[0]
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [oas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [oas_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDXW = $clog2(SECTORS);
	localparam logic [IDXW-1:0] HALF = IDXW'(SECTORS / 2);

	// configuration
	logic [oas_pkg::RANGE_W-1:0] thr_q;
	logic [oas_pkg::DEG_W-1:0]   off_q;
	logic [oas_pkg::DEG_W-1:0]   band_q;
	logic [oas_pkg::DEAD_W-1:0]  dead_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= oas_pkg::THRESHOLD_RST;
			off_q  <= oas_pkg::OFFSET_RST;
			band_q <= oas_pkg::BAND_RST;
			dead_q <= oas_pkg::DEAD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				oas_pkg::CFG_THRESHOLD: thr_q  <= cfg_data;
				oas_pkg::CFG_OFFSET:    off_q  <= cfg_data[oas_pkg::DEG_W-1:0];
				oas_pkg::CFG_BAND:      band_q <= cfg_data[oas_pkg::DEG_W-1:0];
				oas_pkg::CFG_DEAD:      dead_q <= cfg_data[oas_pkg::DEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [oas_pkg::SECTOR_W-1:0] in_sector;
	logic [oas_pkg::RANGE_W-1:0]  in_range;
	logic [oas_pkg::DEG_W-1:0]    in_raw;
	logic [oas_pkg::DEG_W-1:0]    in_tgt;

	assign in_sector = s_tdata[6:0];
	assign in_range  = s_tdata[22:7];
	assign in_raw    = s_tdata[31:23];
	assign in_tgt    = s_tdata[40:32];

	function automatic logic [oas_pkg::DEG_W-1:0] wrap360(input logic [oas_pkg::DEG_W-1:0] v);
		wrap360 = (v >= oas_pkg::FULL_TURN) ? (v - oas_pkg::FULL_TURN) : v;
	endfunction

	logic                         s_acc;
	logic                         scan_wr;
	logic                         decide_go;
	logic [oas_pkg::DEG_W:0]      head_diff;
	logic [oas_pkg::DEG_W-1:0]    head_corr;

	assign s_acc     = s_tvalid && s_tready;
	assign scan_wr   = s_acc && (s_tuser == oas_pkg::OP_SCAN);
	assign decide_go = s_acc && (s_tuser == oas_pkg::OP_DECIDE);

	// corrected heading wrapped into 0..359
	assign head_diff = {1'b0, wrap360(in_raw)} - {1'b0, wrap360(off_q)};
	assign head_corr = head_diff[oas_pkg::DEG_W] ?
		(head_diff[oas_pkg::DEG_W-1:0] + oas_pkg::FULL_TURN) : head_diff[oas_pkg::DEG_W-1:0];

	logic [oas_pkg::DEG_W-1:0] head_q;
	logic [oas_pkg::DEG_W-1:0] tgt_q;

	always_ff @(posedge clk) begin
		if (decide_go) begin
			head_q <= head_corr;
			tgt_q  <= wrap360(in_tgt);
		end
	end

	// chain of range cells
	logic                        ch_vld [SECTORS+1];
	logic [oas_pkg::RANGE_W-1:0] ch_val [SECTORS+1];
	logic [IDXW-1:0]             ch_idx [SECTORS+1];

	assign ch_vld[0] = decide_go;
	assign ch_val[0] = '1;
	assign ch_idx[0] = '0;

	for (genvar k = 0; k < SECTORS; k++) begin : g_cell
		oas_cell #(
			.SECTORS (SECTORS),
			.IDXW    (IDXW),
			.K       (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (scan_wr),
			.wr_sector (in_sector),
			.wr_range  (in_range),
			.in_vld    (ch_vld[k]),
			.in_val    (ch_val[k]),
			.in_idx    (ch_idx[k]),
			.out_vld   (ch_vld[k+1]),
			.out_val   (ch_val[k+1]),
			.out_idx   (ch_idx[k+1])
		);
	end

	// control
	oas_pkg::state_t state_q, state_nxt;
	logic cap;
	logic load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oas_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	logic m_tvalid_q;

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		cap       = 1'b0;
		load      = 1'b0;
		case (state_q)
			oas_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == oas_pkg::OP_DECIDE)) begin
					state_nxt = oas_pkg::ST_SWEEP;
				end
			end
			oas_pkg::ST_SWEEP: begin
				if (ch_vld[SECTORS]) begin
					cap       = 1'b1;
					state_nxt = oas_pkg::ST_RESULT;
				end
			end
			oas_pkg::ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					load      = 1'b1;
					state_nxt = oas_pkg::ST_IDLE;
				end
			end
			default: state_nxt = oas_pkg::ST_IDLE;
		endcase
	end

	logic [oas_pkg::RANGE_W-1:0] min_q;
	logic [IDXW-1:0]             min_idx_q;

	always_ff @(posedge clk) begin
		if (cap) begin
			min_q     <= ch_val[SECTORS];
			min_idx_q <= ch_idx[SECTORS];
		end
	end

	// decision
	logic [oas_pkg::SIDE_W-1:0] side_q, side_nxt, side_now;
	logic [oas_pkg::FLIP_W-1:0] flip_q, flip_nxt;
	logic [oas_pkg::LIN_W-1:0]  lin;
	logic signed [oas_pkg::ANG_W-1:0] ang;
	logic                       mode;
	logic signed [11:0]         d, dp, dm, bnd, ddb;
	logic                       left, right;

	always_comb begin
		d   = signed'({3'b000, head_q}) - signed'({3'b000, tgt_q});
		dp  = d + 12'sd360;
		dm  = d - 12'sd360;
		bnd = signed'({3'b000, band_q});
		ddb = signed'({4'b0000, dead_q});
		left  = ((d <= bnd) && (d > ddb)) || ((dp <= bnd) && (dp > ddb));
		right = ((d < -ddb) && (d >= -bnd)) || ((dm <= -ddb) && (dm >= -bnd));
		side_now = (min_idx_q <= HALF) ? oas_pkg::SIDE_LOW : oas_pkg::SIDE_HIGH;
		side_nxt = side_q;
		flip_nxt = flip_q;
		if (min_q <= thr_q) begin
			mode     = 1'b1;
			lin      = oas_pkg::LIN_STOP;
			side_nxt = side_now;
			if (flip_q >= oas_pkg::FLIP_LIMIT) begin
				ang = oas_pkg::ANG_SPIN_R;
			end else begin
				ang = (side_now == oas_pkg::SIDE_LOW) ? oas_pkg::ANG_SPIN_L : oas_pkg::ANG_SPIN_R;
				if ((side_q != oas_pkg::SIDE_NONE) && (side_q != side_now)) begin
					flip_nxt = flip_q + 2'd1;
				end
			end
		end else begin
			mode     = 1'b0;
			flip_nxt = '0;
			if (left) begin
				lin = oas_pkg::LIN_STEER;
				ang = oas_pkg::ANG_STEER_L;
			end else if (right) begin
				lin = oas_pkg::LIN_STEER;
				ang = oas_pkg::ANG_STEER_R;
			end else if (d == 12'sd0) begin
				lin = oas_pkg::LIN_CRUISE;
				ang = oas_pkg::ANG_ZERO;
			end else begin
				lin = oas_pkg::LIN_STOP;
				ang = oas_pkg::ANG_SPIN_R;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= oas_pkg::SIDE_NONE;
			flip_q <= '0;
		end else if (load) begin
			side_q <= side_nxt;
			flip_q <= flip_nxt;
		end
	end

	// output register
	logic [oas_pkg::LIN_W-1:0] lin_q;
	logic [oas_pkg::ANG_W-1:0] ang_q;
	logic                      mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lin_q  <= lin;
			ang_q  <= ang;
			mode_q <= mode;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, ang_q, lin_q};
	assign m_tuser  = mode_q;

endmodule

FILE: hdl/oas_checker.sv
module oas_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [oas_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a decide transaction blocks the input while the chain sweeps
	a_decide_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == oas_pkg::OP_DECIDE) |=> !s_tready)
		else $error("input taken during sweep");

	// obstacle decisions always stop
	a_obst_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[4:0] == oas_pkg::LIN_STOP) &&
			((m_tdata[11:5] == oas_pkg::ANG_SPIN_L) || (m_tdata[11:5] == oas_pkg::ANG_SPIN_R)))
		else $error("obstacle result not a spin");

	// free decisions pair speed and turn rate
	a_free_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			((m_tdata[4:0] == oas_pkg::LIN_STEER) &&
				((m_tdata[11:5] == oas_pkg::ANG_STEER_L) ||
				(m_tdata[11:5] == oas_pkg::ANG_STEER_R))) ||
			((m_tdata[4:0] == oas_pkg::LIN_CRUISE) && (m_tdata[11:5] == oas_pkg::ANG_ZERO)) ||
			((m_tdata[4:0] == oas_pkg::LIN_STOP) && (m_tdata[11:5] == oas_pkg::ANG_SPIN_R)))
		else $error("free result has bad speed pair");

endmodule

bind obstacle_avoid_steering_top oas_checker u_oas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/obstacle_avoid_steering_top_tb.sv
`timescale 1ns / 100ps

module obstacle_avoid_steering_top_tb;

	localparam int N_SECT     = oas_pkg::SECTORS_DEF;
	localparam int ITEMS      = 1300;
	localparam int TAIL_ITEMS = 120;
	localparam int SETTLE     = N_SECT + 12;
	localparam int LONG_HOLD  = 400;
	localparam int MAX_CYCLES = 800000;

	typedef enum logic [1:0] {
		FEED_ITEM,
		FEED_CFG,
		FEED_PAUSE,
		FEED_HOLD
	} feed_kind_t;

	typedef struct {
		feed_kind_t                      kind;
		logic                            op;
		logic [oas_pkg::SECTOR_W-1:0]    sector;
		logic [oas_pkg::RANGE_W-1:0]     rng;
		logic [oas_pkg::DEG_W-1:0]       raw;
		logic [oas_pkg::DEG_W-1:0]       tgt;
		logic [oas_pkg::CFG_IDX_W-1:0]   idx;
		logic [oas_pkg::CFG_DATA_W-1:0]  val;
		bit                              tail;
	} feed_t;

	typedef struct {
		logic [oas_pkg::LIN_W-1:0]         lin;
		logic signed [oas_pkg::ANG_W-1:0]  ang;
		logic                              mode;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [oas_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = oas_pkg::OP_SCAN;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [oas_pkg::M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [oas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [oas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	obstacle_avoid_steering_top #(.SECTORS(N_SECT)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// steering predictor state
	logic [oas_pkg::RANGE_W-1:0] ranges_mm [N_SECT];
	logic [oas_pkg::SIDE_W-1:0]  obst_side;
	logic [oas_pkg::FLIP_W-1:0]  flip_cnt;
	logic [oas_pkg::RANGE_W-1:0] thr_mm;
	logic [oas_pkg::DEG_W-1:0]   off_deg;
	logic [oas_pkg::DEG_W-1:0]   band_deg;
	logic [oas_pkg::DEAD_W-1:0]  dead_deg;

	steer_t steer_due[$];
	feed_t  feed_q[$];

	// stimulus planning view of the block
	int g_store [N_SECT];
	int g_thr, g_off, g_band, g_dead;
	int n_planned = 0;

	int cyc = 0;
	int n_err = 0;
	int n_scan = 0, n_decide = 0, n_cfg = 0, n_results = 0, n_obst = 0;
	int gap_cnt = 0, settle_cnt = 0;
	bit draining = 1'b0;
	logic hold_kick = 1'b0;
	logic tail_mode = 1'b0;

	function automatic int wrap360(input int x);
		return ((x % 360) + 360) % 360;
	endfunction

	function automatic steer_t steer_predict(input logic [oas_pkg::DEG_W-1:0] raw,
			input logic [oas_pkg::DEG_W-1:0] tgt);
		steer_t res;
		int head, diff, b, d, min_idx;
		logic [oas_pkg::RANGE_W-1:0] min_mm;
		logic [oas_pkg::SIDE_W-1:0] side;
		head = int'(raw) % 360 - int'(off_deg) % 360;
		if (head < 0) head += 360;
		diff = head - int'(tgt) % 360;
		min_idx = 0;
		min_mm = ranges_mm[0];
		for (int k = 1; k < N_SECT; k++) begin
			if (ranges_mm[k] < min_mm) begin
				min_mm = ranges_mm[k];
				min_idx = k;
			end
		end
		if (min_mm <= thr_mm) begin
			side = (min_idx <= N_SECT / 2) ? oas_pkg::SIDE_LOW : oas_pkg::SIDE_HIGH;
			res.lin = oas_pkg::LIN_STOP;
			res.mode = 1'b1;
			if (flip_cnt >= oas_pkg::FLIP_LIMIT) begin
				res.ang = oas_pkg::ANG_SPIN_R;
			end else begin
				res.ang = (side == oas_pkg::SIDE_LOW) ? oas_pkg::ANG_SPIN_L : oas_pkg::ANG_SPIN_R;
				if (obst_side != oas_pkg::SIDE_NONE && obst_side != side) flip_cnt++;
			end
			obst_side = side;
		end else begin
			b = int'(band_deg);
			d = int'(dead_deg);
			flip_cnt = '0;
			res.mode = 1'b0;
			if ((diff <= b && diff > d) || (diff + 360 <= b && diff + 360 > d)) begin
				res.lin = oas_pkg::LIN_STEER;
				res.ang = oas_pkg::ANG_STEER_L;
			end else if ((diff < -d && diff >= -b) ||
					(diff - 360 <= -d && diff - 360 >= -b)) begin
				res.lin = oas_pkg::LIN_STEER;
				res.ang = oas_pkg::ANG_STEER_R;
			end else if (diff == 0) begin
				res.lin = oas_pkg::LIN_CRUISE;
				res.ang = oas_pkg::ANG_ZERO;
			end else begin
				res.lin = oas_pkg::LIN_STOP;
				res.ang = oas_pkg::ANG_SPIN_R;
			end
		end
		return res;
	endfunction

	task automatic log_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cyc, what);
		n_err++;
	endtask

	task automatic plan(input feed_kind_t kind, input logic op, input int sector, input int rng,
			input int raw, input int tgt, input int idx, input int val);
		feed_t f;
		f.kind = kind;
		f.op = op;
		f.sector = sector[oas_pkg::SECTOR_W-1:0];
		f.rng = rng[oas_pkg::RANGE_W-1:0];
		f.raw = raw[oas_pkg::DEG_W-1:0];
		f.tgt = tgt[oas_pkg::DEG_W-1:0];
		f.idx = idx[oas_pkg::CFG_IDX_W-1:0];
		f.val = val[oas_pkg::CFG_DATA_W-1:0];
		f.tail = (n_planned >= ITEMS - TAIL_ITEMS);
		feed_q.insert(feed_q.size(), f);
	endtask

	task automatic plan_scan(input int sector, input int rng);
		plan(FEED_ITEM, oas_pkg::OP_SCAN, sector, rng, $urandom_range(0, 511),
			$urandom_range(0, 511), 0, 0);
		// out-of-range sectors are dropped by the block and not counted
		if (sector < N_SECT) begin
			g_store[sector] = rng;
			n_planned++;
		end
	endtask

	task automatic plan_decide(input int raw, input int tgt);
		plan(FEED_ITEM, oas_pkg::OP_DECIDE, $urandom_range(0, 127), $urandom_range(0, 65535),
			raw, tgt, 0, 0);
		n_planned++;
	endtask

	// decide whose corrected heading sits d degrees from the target
	task automatic plan_aimed(input int d, input int tgt);
		int raw, goal;
		raw = wrap360(wrap360(tgt + d) + g_off % 360);
		goal = tgt;
		if (raw + 360 < 512 && $urandom_range(0, 4) == 0) raw += 360;
		if (goal + 360 < 512 && $urandom_range(0, 4) == 0) goal += 360;
		plan_decide(raw, goal);
	endtask

	function automatic int edge_diff();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return g_dead;
			2: return g_dead + 1;
			3: return g_band;
			4: return g_band + 1;
			5: return -g_dead;
			6: return -g_dead - 1;
			7: return -g_band;
			8: return -g_band - 1;
			default: return int'($urandom_range(0, 718)) - 359;
		endcase
	endfunction

	task automatic plan_settings(input int thr, input int off, input int band, input int dead,
			input bit junk);
		int hi_off, hi_dead;
		hi_off = junk ? ($urandom_range(0, 127) << oas_pkg::DEG_W) : 0;
		hi_dead = junk ? ($urandom_range(0, 255) << oas_pkg::DEAD_W) : 0;
		plan(FEED_PAUSE, oas_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
		plan(FEED_CFG, oas_pkg::OP_SCAN, 0, 0, 0, 0, oas_pkg::CFG_THRESHOLD, thr);
		plan(FEED_CFG, oas_pkg::OP_SCAN, 0, 0, 0, 0, oas_pkg::CFG_OFFSET,
			(off | hi_off) & 16'hffff);
		plan(FEED_CFG, oas_pkg::OP_SCAN, 0, 0, 0, 0, oas_pkg::CFG_BAND,
			(band | hi_off) & 16'hffff);
		plan(FEED_CFG, oas_pkg::OP_SCAN, 0, 0, 0, 0, oas_pkg::CFG_DEAD,
			(dead | hi_dead) & 16'hffff);
		g_thr = thr;
		g_off = off & 511;
		g_band = band & 511;
		g_dead = dead & 255;
	endtask

	// lift every sector at or below the threshold out of obstacle range
	task automatic plan_clear();
		if (g_thr < 65535) begin
			for (int k = 0; k < N_SECT; k++)
				if (g_store[k] <= g_thr) plan_scan(k, $urandom_range(g_thr + 1, 65535));
		end
	endtask

	task automatic plan_episode();
		int pick, a, b, v;
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			// an obstacle on a random side, at, next to or below the threshold
			if ($urandom_range(0, 9) < 6) plan_clear();
			a = $urandom_range(0, 1) ? $urandom_range(0, N_SECT / 2)
				: $urandom_range(N_SECT / 2 + 1, N_SECT - 1);
			case ($urandom_range(0, 3))
				0: v = g_thr;
				1: v = (g_thr > 0) ? g_thr - 1 : 0;
				2: v = $urandom_range(0, g_thr);
				default: v = (g_thr < 65535) ? g_thr + 1 : g_thr;
			endcase
			plan_scan(a, v);
			repeat ($urandom_range(1, 2)) plan_aimed(edge_diff(), $urandom_range(0, 359));
		end else if (pick < 12) begin
			plan_clear();
			repeat ($urandom_range(1, 3)) plan_aimed(edge_diff(), $urandom_range(0, 359));
		end else if (pick < 17) begin
			repeat ($urandom_range(3, 10)) begin
				if ($urandom_range(0, 4) == 0)
					plan_decide($urandom_range(0, 511), $urandom_range(0, 511));
				else
					plan_scan($urandom_range(0, 127), $urandom_range(0, 65535));
			end
		end else begin
			// equal minimum in two sectors: the lower index must win
			plan_clear();
			v = $urandom_range(0, g_thr);
			a = $urandom_range(0, N_SECT - 2);
			b = $urandom_range(a + 1, N_SECT - 1);
			plan_scan(b, v);
			plan_scan(a, v);
			plan_aimed(edge_diff(), $urandom_range(0, 359));
		end
	endtask

	// driver: feeds stream and config transactions, predicts on acceptance
	always @(posedge clk) begin : feed_driver
		feed_t f;
		logic nv_s, nv_c, nk;
		bit tx_bursty;
		if (arst_n) begin
			nv_s = s_tvalid;
			nv_c = cfg_valid;
			nk = 1'b0;
			if (cyc % 128 == 0) tx_bursty = ($urandom_range(0, 2) != 0);
			if (s_tvalid && s_tready) begin
				// tdata: sector[6:0] range[22:7] heading_raw[31:23] heading_target[40:32]
				if (s_tuser == oas_pkg::OP_DECIDE) begin
					steer_due.insert(steer_due.size(),
						steer_predict(s_tdata[31:23], s_tdata[40:32]));
					n_decide++;
				end else if (s_tdata[6:0] < N_SECT) begin
					ranges_mm[s_tdata[6:0]] = s_tdata[22:7];
					n_scan++;
				end
				nv_s = 1'b0;
				if (!tail_mode && tx_bursty && $urandom_range(0, 4) == 0)
					gap_cnt = $urandom_range(1, 19);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					oas_pkg::CFG_THRESHOLD: thr_mm = cfg_data;
					oas_pkg::CFG_OFFSET:    off_deg = cfg_data[oas_pkg::DEG_W-1:0];
					oas_pkg::CFG_BAND:      band_deg = cfg_data[oas_pkg::DEG_W-1:0];
					oas_pkg::CFG_DEAD:      dead_deg = cfg_data[oas_pkg::DEAD_W-1:0];
					default: ;
				endcase
				n_cfg++;
				nv_c = 1'b0;
			end
			if (!nv_s && !nv_c) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (draining) begin
					// scans leave no result, so allow a full sweep after the last one
					if (steer_due.size() == 0) begin
						if (settle_cnt >= SETTLE) draining = 1'b0;
						else settle_cnt++;
					end
				end else if (feed_q.size() > 0) begin
					f = feed_q[0];
					feed_q.delete(0);
					case (f.kind)
						FEED_ITEM: begin
							nv_s = 1'b1;
							s_tdata <= {7'd0, f.tgt, f.raw, f.rng, f.sector};
							s_tuser <= f.op;
							tail_mode <= f.tail;
						end
						FEED_CFG: begin
							nv_c = 1'b1;
							cfg_index <= f.idx;
							cfg_data <= f.val;
						end
						FEED_PAUSE: begin
							draining = 1'b1;
							settle_cnt = 0;
						end
						FEED_HOLD: nk = 1'b1;
						default: ;
					endcase
				end
			end
			s_tvalid <= nv_s;
			cfg_valid <= nv_c;
			hold_kick <= nk;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin : result_ready
		logic nr;
		int long_left, stall_left;
		bit rx_bursty;
		if (arst_n) begin
			nr = 1'b1;
			if (cyc % 96 == 0) rx_bursty = ($urandom_range(0, 2) != 0);
			if (long_left > 0) begin
				long_left--;
				nr = 1'b0;
			end else if (hold_kick) begin
				long_left = LONG_HOLD;
				nr = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nr = 1'b0;
			end else if (rx_bursty && !tail_mode && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				nr = 1'b0;
			end
			m_tready <= nr;
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		steer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			// tdata: linear_speed[4:0] angular_speed[11:5]; tuser: obstacle_mode
			got.lin = m_tdata[4:0];
			got.ang = m_tdata[11:5];
			got.mode = m_tuser;
			n_results++;
			if (got.mode) n_obst++;
			if (steer_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result lin %0d ang %0d mode %0d",
					got.lin, got.ang, got.mode));
			end else begin
				want = steer_due[0];
				steer_due.delete(0);
				if (got.lin !== want.lin)
					log_mismatch($sformatf("linear_speed %0d, expected %0d", got.lin, want.lin));
				if (got.ang !== want.ang)
					log_mismatch($sformatf("angular_speed %0d, expected %0d", got.ang, want.ang));
				if (got.mode !== want.mode)
					log_mismatch($sformatf("obstacle_mode %0d, expected %0d", got.mode,
						want.mode));
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= MAX_CYCLES) begin
			$display("timeout after %0d cycles", cyc);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < N_SECT; k++) begin
			ranges_mm[k] = oas_pkg::PRESET_RANGE;
			g_store[k] = oas_pkg::PRESET_RANGE;
		end
		obst_side = oas_pkg::SIDE_NONE;
		flip_cnt = '0;
		thr_mm = oas_pkg::THRESHOLD_RST;
		off_deg = oas_pkg::OFFSET_RST;
		band_deg = oas_pkg::BAND_RST;
		dead_deg = oas_pkg::DEAD_RST;
		g_thr = oas_pkg::THRESHOLD_RST;
		g_off = oas_pkg::OFFSET_RST;
		g_band = oas_pkg::BAND_RST;
		g_dead = oas_pkg::DEAD_RST;

		// directed part at reset settings: heading cases first, store all clear
		plan_decide(25, 0);
		plan_decide(0, 0);
		plan_decide(511, 511);
		plan_aimed(2, 100);
		plan_aimed(1, 100);
		plan_aimed(150, 200);
		plan_aimed(151, 200);
		plan_aimed(-150, 10);
		// obstacle low, then high at exactly the threshold, then low again
		plan_scan(0, 0);
		plan_decide(25, 0);
		plan_scan(0, 65535);
		plan_scan(N_SECT - 1, 400);
		plan_decide(300, 40);
		plan_scan(N_SECT - 1, 65535);
		plan_scan(N_SECT / 2, 399);
		plan_decide(100, 359);
		// two side changes seen: spin right regardless of side
		plan_decide(200, 0);
		plan_scan(N_SECT / 2, 401);
		plan_decide(125, 100);
		plan_scan(N_SECT / 2 + 1, 100);
		plan_decide(10, 20);
		plan_scan(10, 100);
		plan_decide(50, 50);
		plan_scan(127, 0);
		plan_scan(N_SECT, 0);

		for (int ph = 1; ph <= 6; ph++) begin
			case (ph)
				1: plan_settings(0, 0, 359, 0, 1'b0);
				2: plan_settings(65535, 359, 1, 179, 1'b0);
				3: plan_settings($urandom_range(300, 2000), 511, 511, 255, 1'b0);
				4: plan_settings($urandom_range(100, 5000), $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 255), 1'b1);
				5: plan_settings($urandom_range(0, 20000), $urandom_range(0, 359),
					$urandom_range(1, 359), $urandom_range(0, 179), 1'b0);
				default: plan_settings(oas_pkg::THRESHOLD_RST, oas_pkg::OFFSET_RST,
					oas_pkg::BAND_RST, oas_pkg::DEAD_RST, 1'b0);
			endcase
			if (ph == 3) begin
				// results back up while decides keep coming
				plan(FEED_HOLD, oas_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0);
				repeat (12) plan_aimed(edge_diff(), $urandom_range(0, 359));
			end
			while (n_planned < 25 + ph * (ITEMS - 25) / 6) plan_episode();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || s_tvalid || cfg_valid || draining || steer_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (steer_due.size() != 0)
			log_mismatch($sformatf("%0d steering results never arrived", steer_due.size()));

		$display("covered %0d scan and %0d decide transactions, %0d register writes",
			n_scan, n_decide, n_cfg);
		$display("checked %0d steering results, %0d from obstacle avoidance, %0d mismatches",
			n_results, n_obst, n_err);
		if (n_err == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
